/* hdl/mids_pkg.sv */
// ----------------------------------------------------------------------------
// Motor ID scan sequencer package
// Shared types and codes for the scan sequencer: phases, actions, register
// indexes, the configuration set and the input and result items.
// ----------------------------------------------------------------------------
package mids_pkg;

	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		PH_DISARMED = 3'd0,
		PH_WAIT     = 3'd1,
		PH_FORWARD  = 3'd2,
		PH_REVERSE  = 3'd3,
		PH_SETTLE   = 3'd4,
		PH_COMPLETE = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_RUN      = 2'd1,
		ACT_STOP     = 2'd2,
		ACT_STOP_ALL = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_NUM_MOTORS        = 3'd0,
		REG_MAX_SPEED         = 3'd1,
		REG_ONLINE_WAIT_LIMIT = 3'd2,
		REG_MOTION_LIMIT      = 3'd3,
		REG_TRAVEL_DISTANCE   = 3'd4,
		REG_RETURN_TOLERANCE  = 3'd5,
		REG_SETTLE_TIME       = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic        [7:0]  num_motors;
		logic signed [31:0] max_speed;
		logic        [31:0] online_wait_limit;
		logic        [31:0] motion_limit;
		logic signed [31:0] travel_distance;
		logic        [30:0] return_tolerance;
		logic        [31:0] settle_time;
	} cfg_t;

	typedef struct packed {
		logic               scan_enable;
		logic               motor_online;
		logic        [31:0] time_now;
		logic signed [31:0] angle_now;
	} in_item_t;

	typedef struct packed {
		logic        [1:0]  action;
		logic        [7:0]  motor_number;
		logic signed [31:0] speed_ref;
	} out_item_t;

endpackage

/* hdl/mids_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Scan sequencer configuration registers
// APB-style register bank holding the scan limits, speeds and distances.
// ----------------------------------------------------------------------------
module mids_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mids_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output mids_pkg::cfg_t              cfg
);

	mids_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[mids_pkg::ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_motors        <= 8'd1;
			cfg_q.max_speed         <= '0;
			cfg_q.online_wait_limit <= '0;
			cfg_q.motion_limit      <= '0;
			cfg_q.travel_distance   <= '0;
			cfg_q.return_tolerance  <= '0;
			cfg_q.settle_time       <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				mids_pkg::REG_NUM_MOTORS:        cfg_q.num_motors        <= pwdata[7:0];
				mids_pkg::REG_MAX_SPEED:         cfg_q.max_speed         <= pwdata;
				mids_pkg::REG_ONLINE_WAIT_LIMIT: cfg_q.online_wait_limit <= pwdata;
				mids_pkg::REG_MOTION_LIMIT:      cfg_q.motion_limit      <= pwdata;
				mids_pkg::REG_TRAVEL_DISTANCE:   cfg_q.travel_distance   <= pwdata;
				mids_pkg::REG_RETURN_TOLERANCE:  cfg_q.return_tolerance  <= pwdata[30:0];
				mids_pkg::REG_SETTLE_TIME:       cfg_q.settle_time       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mids_pkg::REG_NUM_MOTORS:        prdata = {24'd0, cfg_q.num_motors};
			mids_pkg::REG_MAX_SPEED:         prdata = cfg_q.max_speed;
			mids_pkg::REG_ONLINE_WAIT_LIMIT: prdata = cfg_q.online_wait_limit;
			mids_pkg::REG_MOTION_LIMIT:      prdata = cfg_q.motion_limit;
			mids_pkg::REG_TRAVEL_DISTANCE:   prdata = cfg_q.travel_distance;
			mids_pkg::REG_RETURN_TOLERANCE:  prdata = {1'b0, cfg_q.return_tolerance};
			mids_pkg::REG_SETTLE_TIME:       prdata = cfg_q.settle_time;
			default:                         prdata = '0;
		endcase
	end

endmodule

/* hdl/mids_seq_core.sv */
// ----------------------------------------------------------------------------
// Scan sequencer state machine
// Holds the scan state and computes, for one tick, the next state and the
// action, motor number and speed reference.
// ----------------------------------------------------------------------------
module mids_seq_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  mids_pkg::in_item_t   item,
	input  mids_pkg::cfg_t       cfg,
	output mids_pkg::out_item_t  res,
	output mids_pkg::phase_t     phase
);

	mids_pkg::phase_t   phase_q, phase_d;
	logic        [7:0]  motor_q, motor_d;
	logic        [31:0] start_q, start_d;
	logic signed [31:0] origin_q, origin_d;

	logic        [31:0] elapsed;
	logic               wait_done, motion_done, settle_done;
	logic        [7:0]  motor_inc;
	logic               last_motor;
	logic               do_adv;
	logic               ms_min;
	logic signed [31:0] speed_fwd, speed_rev;
	logic signed [32:0] target;
	logic signed [33:0] delta;
	logic        [32:0] delta_abs;
	logic               reached_travel, back_home;

	assign phase = phase_q;

	// Wrapping elapsed time since the phase began.
	assign elapsed     = item.time_now - start_q;
	assign wait_done   = elapsed >= cfg.online_wait_limit;
	assign motion_done = elapsed >= cfg.motion_limit;
	assign settle_done = elapsed >= cfg.settle_time;

	assign motor_inc  = motor_q + 8'd1;
	assign last_motor = motor_inc >= cfg.num_motors;

	// The clamp only bites for the most negative speed, whose magnitude saturates.
	assign ms_min    = cfg.max_speed == 32'sh8000_0000;
	assign speed_fwd = ms_min ? 32'sh8000_0001 : cfg.max_speed;
	assign speed_rev = ms_min ? 32'sh7FFF_FFFF : -cfg.max_speed;

	assign target = {origin_q[31], origin_q} + {cfg.travel_distance[31], cfg.travel_distance};
	assign reached_travel = $signed({item.angle_now[31], item.angle_now}) >= target;

	// The difference of two 32-bit angles is held in 34 signed bits.
	assign delta     = $signed({{2{item.angle_now[31]}}, item.angle_now})
		- $signed({{2{origin_q[31]}}, origin_q});
	assign delta_abs = delta[33] ? 33'(-delta) : 33'(delta);
	assign back_home = delta_abs <= {2'b00, cfg.return_tolerance};

	always_comb begin
		phase_d          = phase_q;
		motor_d          = motor_q;
		start_d          = start_q;
		origin_d         = origin_q;
		do_adv           = 1'b0;
		res.action       = mids_pkg::ACT_NONE;
		res.motor_number = motor_q;
		res.speed_ref    = '0;
		if (!item.scan_enable) begin
			phase_d          = mids_pkg::PH_DISARMED;
			motor_d          = '0;
			start_d          = item.time_now;
			origin_d         = '0;
			res.action       = mids_pkg::ACT_STOP_ALL;
			res.motor_number = '0;
		end else begin
			case (phase_q)
				mids_pkg::PH_DISARMED: begin
					phase_d    = mids_pkg::PH_WAIT;
					start_d    = item.time_now;
					res.action = mids_pkg::ACT_STOP;
				end
				mids_pkg::PH_WAIT: begin
					if (item.motor_online) begin
						origin_d      = item.angle_now;
						phase_d       = mids_pkg::PH_FORWARD;
						start_d       = item.time_now;
						res.action    = mids_pkg::ACT_RUN;
						res.speed_ref = speed_fwd;
					end else if (wait_done) begin
						do_adv = 1'b1;
					end else begin
						res.action = mids_pkg::ACT_STOP;
					end
				end
				mids_pkg::PH_FORWARD: begin
					if (!item.motor_online || motion_done) begin
						do_adv = 1'b1;
					end else if (reached_travel) begin
						phase_d       = mids_pkg::PH_REVERSE;
						start_d       = item.time_now;
						res.action    = mids_pkg::ACT_RUN;
						res.speed_ref = speed_rev;
					end else begin
						res.action    = mids_pkg::ACT_RUN;
						res.speed_ref = speed_fwd;
					end
				end
				mids_pkg::PH_REVERSE: begin
					if (!item.motor_online || motion_done) begin
						do_adv = 1'b1;
					end else if (back_home) begin
						phase_d    = mids_pkg::PH_SETTLE;
						start_d    = item.time_now;
						res.action = mids_pkg::ACT_STOP;
					end else begin
						res.action    = mids_pkg::ACT_RUN;
						res.speed_ref = speed_rev;
					end
				end
				mids_pkg::PH_SETTLE: begin
					if (settle_done) begin
						do_adv = 1'b1;
					end else begin
						res.action = mids_pkg::ACT_STOP;
					end
				end
				default: begin
					res.action = mids_pkg::ACT_STOP_ALL;
				end
			endcase

			// Move on to the next motor, or finish when the last one is done.
			if (do_adv) begin
				if (last_motor) begin
					phase_d    = mids_pkg::PH_COMPLETE;
					res.action = mids_pkg::ACT_STOP_ALL;
				end else begin
					motor_d    = motor_inc;
					phase_d    = mids_pkg::PH_WAIT;
					start_d    = item.time_now;
					origin_d   = '0;
					res.action = mids_pkg::ACT_STOP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mids_pkg::PH_DISARMED;
			motor_q  <= '0;
			start_q  <= '0;
			origin_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			motor_q  <= motor_d;
			start_q  <= start_d;
			origin_q <= origin_d;
		end
	end

endmodule

/* hdl/motor_id_scan_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Motor ID scan sequencer
// Steps through the motors one at a time: wait for online, drive forward by
// the travel distance, drive back to the start angle, settle, next motor.
// ----------------------------------------------------------------------------
// Path: an accepted tick goes through the input register, then the result
// register, where its result is held while out_stall is high.
// Throughput: one tick per cycle while out_stall does not hold a result; the state registers update once per tick.
// Reset: arst_n puts the scan in the disarmed phase at motor 0, empties both
// pipeline stages and loads the register defaults (one motor, others 0).
module motor_id_scan_sequencer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mids_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        scan_enable,
	input  logic                        motor_online,
	input  logic [31:0]                 time_now,
	input  logic signed [31:0]          angle_now,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  action,
	output logic [7:0]                  motor_number,
	output logic signed [31:0]          speed_ref
);

	mids_pkg::cfg_t      cfg;
	mids_pkg::in_item_t  item_s1;
	logic                valid_s1;
	mids_pkg::out_item_t res_s2;
	logic                valid_s2;
	mids_pkg::out_item_t res;
	mids_pkg::phase_t    phase;
	logic                out_free;
	logic                step;
	logic                accept;

	mids_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_free = !valid_s2 || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !step);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.scan_enable  <= scan_enable;
			item_s1.motor_online <= motor_online;
			item_s1.time_now     <= time_now;
			item_s1.angle_now    <= angle_now;
		end
	end

	mids_seq_core u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res),
		.phase  (phase)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign action       = res_s2.action;
	assign motor_number = res_s2.motor_number;
	assign speed_ref    = res_s2.speed_ref;

	// A tick with the scan disabled always leaves the sequencer disarmed.
	a_disable_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item_s1.scan_enable |=> phase == mids_pkg::PH_DISARMED)
		else $error("disabled tick did not disarm the scan");

	// Once complete, the scan stays complete while it remains enabled.
	a_complete_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && item_s1.scan_enable && phase == mids_pkg::PH_COMPLETE
		|=> phase == mids_pkg::PH_COMPLETE)
		else $error("complete scan left the complete phase while enabled");

	// A run result is only ever produced by a tick that puts the scan in a motion phase.
	a_run_in_motion: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.action == mids_pkg::ACT_RUN
		|-> phase == mids_pkg::PH_FORWARD || phase == mids_pkg::PH_REVERSE)
		else $error("run action outside forward or reverse phase");

endmodule
